// ----- src/pse_pkg.sv -----
// Shared types and constants for the postfix stack evaluator.
// Token codes, status codes, the queued command format and beat widths.
// No dependencies.
`default_nettype none

package pse_pkg;

  // Default sizes for the top-level parameters
  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  // Field widths fixed by the token and result formats
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 40;  // 35 bits of fields, padded to whole bytes
  localparam int OUT_W    = 48;  // 42 bits of fields, padded to whole bytes

  // Token kinds on the input
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BADOP = 3'd4;

  // Classified operation
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_BAD
  } op_t;

  // Command queued between front and back
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Control toward the multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

endpackage

`default_nettype wire

// ----- src/postfix_stack_evaluator.sv -----
// Postfix expression evaluator: top level joining front end and back end.
// Depends on pse_pkg, pse_front, pse_back.
//
// Usage:
//   s_* carries one token per beat: func selects push, add, subtract,
//   multiply or divide; operand_value is pushed for a push token.
//   m_* returns one result beat per token: the new top of stack (0 when the
//   stack is empty), the stack depth and a status (ok, underflow, overflow,
//   divide by zero, unsupported operator). On an error the stack is kept.
//   Each token passes from the queue through S_IDLE to S_FIN for a push, an
//   overflow, an underflow or an unsupported operator, also through S_READ
//   for add, subtract and divide by zero, and also through S_EXEC for
//   multiply and divide while the one-bit-per-cycle multiply/divide unit
//   runs. Tokens are carried out one at a time; a two-entry queue takes
//   tokens in while the back end works.
//   Reset (rst, synchronous) empties the stack and the queue and drops any
//   pending result. While m_tready is low the result beat holds; the back
//   end stops after finishing its token and the queue fills, then s_tready
//   falls.
`default_nettype none

module postfix_stack_evaluator
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // func [2:0], operand_value [34:3]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // top_value [31:0], stack_depth [38:32],
                                           // status [41:39]
);

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  pse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  pse_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- src/pse_front.sv -----
// Front end: accepts token beats, classifies the token kind and queues commands.
// Two-entry queue toward the back end. Depends on pse_pkg.
`default_nettype none

module pse_front
  import pse_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,   // func [2:0], operand_value [34:3]
  output logic                 q_valid,
  input  wire logic            q_ready,
  output cmd_t                 q_cmd
);

  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  cmd_t       slot [2];
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  // Classify the token kind
  always_comb begin
    in_cmd.value = s_tdata[FUNC_W +: VALUE_W];
    unique case (s_tdata[FUNC_W-1:0])
      FUNC_PUSH: in_cmd.op = OP_PUSH;
      FUNC_ADD:  in_cmd.op = OP_ADD;
      FUNC_SUB:  in_cmd.op = OP_SUB;
      FUNC_MUL:  in_cmd.op = OP_MUL;
      FUNC_DIV:  in_cmd.op = OP_DIV;
      default:   in_cmd.op = OP_BAD;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/pse_muldiv.sv -----
// Iterative multiply and divide unit, one bit per cycle.
// Multiply keeps the low DATA_WIDTH bits; divide truncates toward zero.
// Depends on pse_pkg.
`default_nettype none

module pse_muldiv
  import pse_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire md_ctl_t               ctl,
  input  wire logic [DATA_WIDTH-1:0] lhs,
  input  wire logic [DATA_WIDTH-1:0] rhs,
  output logic                       done,
  output logic [DATA_WIDTH-1:0]      result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;
  localparam logic [1:0] P_SIGN = 2'd2;

  logic [1:0]            phase;
  logic [CNT_W-1:0]      cnt;
  logic                  is_div;
  logic                  neg;
  logic [DATA_WIDTH-1:0] acc;   // product, or partial remainder
  logic [DATA_WIDTH-1:0] opa;   // multiplicand, or dividend turning into quotient
  logic [DATA_WIDTH-1:0] opb;   // multiplier, or divisor magnitude
  logic [DATA_WIDTH-1:0] shifted;

  // Remainder shifted by one with the next dividend bit
  assign shifted = {acc[DATA_WIDTH-2:0], opa[DATA_WIDTH-1]};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (ctl.start) begin
            phase <= P_RUN;
          end
        end
        P_RUN: begin
          if (cnt == '0) begin
            phase <= P_SIGN;
          end
        end
        P_SIGN: begin
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (phase)
      P_IDLE: begin
        if (ctl.start) begin
          is_div <= ctl.is_div;
          cnt    <= CNT_W'(DATA_WIDTH - 1);
          acc    <= '0;
          neg    <= lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
          if (ctl.is_div) begin
            opa <= lhs[DATA_WIDTH-1] ? -lhs : lhs;
            opb <= rhs[DATA_WIDTH-1] ? -rhs : rhs;
          end else begin
            opa <= lhs;
            opb <= rhs;
          end
        end
      end
      P_RUN: begin
        cnt <= cnt - CNT_W'(1);
        if (is_div) begin
          // restoring division step
          if (shifted >= opb) begin
            acc <= shifted - opb;
            opa <= {opa[DATA_WIDTH-2:0], 1'b1};
          end else begin
            acc <= shifted;
            opa <= {opa[DATA_WIDTH-2:0], 1'b0};
          end
        end else begin
          // shift-add multiply step
          if (opb[0]) begin
            acc <= acc + opa;
          end
          opa <= {opa[DATA_WIDTH-2:0], 1'b0};
          opb <= {1'b0, opb[DATA_WIDTH-1:1]};
        end
      end
      P_SIGN: begin
        if (is_div) begin
          result <= neg ? -opa : opa;
        end else begin
          result <= acc;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pse_back.sv -----
// Back end: stack memory with a top-of-stack register, token sequencer and
// result register. Depends on pse_pkg and pse_muldiv.
`default_nettype none

module pse_back
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire cmd_t             q_cmd,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata   // top_value [31:0], stack_depth [38:32],
                                          // status [41:39]
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]            state;
  logic [CW-1:0]         depth;
  logic [DATA_WIDTH-1:0] tos;
  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  op_t                   op;
  logic [STATUS_W-1:0]   status;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [CW-1:0]         depth_m1;
  logic [CW-1:0]         depth_m2;
  logic signed [63:0]    in_ext;
  logic signed [63:0]    top_ext;
  logic [DATA_WIDTH-1:0] push_val;
  logic                  out_load;
  md_ctl_t               md_ctl;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_result;

  // Entries below the top live in memory; the top lives in tos
  assign depth_m1  = depth - CW'(1);
  assign depth_m2  = depth - CW'(2);
  assign mem_waddr = depth_m1[AW-1:0];
  assign mem_raddr = depth_m2[AW-1:0];
  assign mem_we    = (state == S_IDLE) && q_valid && (q_cmd.op == OP_PUSH) &&
                     (depth != '0) && (depth != CW'(STACK_DEPTH));

  assign in_ext   = 64'(signed'(q_cmd.value));
  assign push_val = in_ext[DATA_WIDTH-1:0];
  assign top_ext  = 64'(signed'(tos));

  assign q_ready  = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  assign md_ctl.start  = (state == S_READ) && ((op == OP_MUL) ||
                         ((op == OP_DIV) && (tos != '0)));
  assign md_ctl.is_div = (op == OP_DIV);

  // Stack memory: spill on push, read second entry for operators
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= tos;
    end
    rd_data <= mem[mem_raddr];
  end

  pse_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctl    (md_ctl),
    .lhs    (rd_data),
    .rhs    (tos),
    .done   (md_done),
    .result (md_result)
  );

  // Sequencer with depth counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op <= q_cmd.op;
            unique case (q_cmd.op)
              OP_PUSH: begin
                state <= S_FIN;
                if (depth == CW'(STACK_DEPTH)) begin
                  status <= STATUS_OVER;
                end else begin
                  status <= STATUS_OK;
                  tos    <= push_val;
                  depth  <= depth + CW'(1);
                end
              end
              OP_BAD: begin
                state  <= S_FIN;
                status <= STATUS_BADOP;
              end
              default: begin
                if (depth < CW'(2)) begin
                  state  <= S_FIN;
                  status <= STATUS_UNDER;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          // left operand in rd_data, right operand in tos
          unique case (op)
            OP_ADD: begin
              tos    <= rd_data + tos;
              depth  <= depth_m1;
              status <= STATUS_OK;
              state  <= S_FIN;
            end
            OP_SUB: begin
              tos    <= rd_data - tos;
              depth  <= depth_m1;
              status <= STATUS_OK;
              state  <= S_FIN;
            end
            default: begin
              if ((op == OP_DIV) && (tos == '0)) begin
                status <= STATUS_DIVZ;
                state  <= S_FIN;
              end else begin
                state <= S_EXEC;
              end
            end
          endcase
        end
        S_EXEC: begin
          if (md_done) begin
            tos    <= md_result;
            depth  <= depth_m1;
            status <= STATUS_OK;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(OUT_W - VALUE_W - DEPTH_W - STATUS_W)'(0), status,
                  DEPTH_W'(depth),
                  (depth != '0) ? top_ext[VALUE_W-1:0] : VALUE_W'(0)};
    end
  end

endmodule

`default_nettype wire

// ----- src/pse_checker.sv -----
// Port-level checks for the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg.
`default_nettype none

module pse_checker
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            s_tvalid,
  input wire logic            s_tready,
  input wire logic [IN_W-1:0] s_tdata,
  input wire logic            m_tvalid,
  input wire logic            m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  logic [STATUS_W-1:0] status;
  logic [DEPTH_W-1:0]  depth;
  logic [VALUE_W-1:0]  top;

  assign status  = m_tdata[41:39];
  assign depth   = m_tdata[38:32];
  assign top     = m_tdata[31:0];

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // Status is a defined code and depth stays within the stack
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (status <= STATUS_BADOP) && (32'(depth) <= 32'(STACK_DEPTH)))
    else $error("undefined status code or depth beyond stack size");

  // An empty stack reports a zero top and never an overflow
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (depth == '0) |-> (top == '0) && (status != STATUS_OVER))
    else $error("empty stack with nonzero top or overflow");

  // A waiting token beat holds until accepted
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("waiting token beat changed");

endmodule

bind postfix_stack_evaluator pse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for postfix_stack_evaluator: directed and random token streams.
// A stack model predicts each result beat, and random stalls are applied on both sides.
// Depends on pse_pkg and the RTL under src/.
`timescale 1ns / 1ps

import pse_pkg::*;

// Expected result beat
typedef struct {
  logic [VALUE_W-1:0]  top;
  logic [DEPTH_W-1:0]  depth;
  logic [STATUS_W-1:0] status;
} eval_result_t;

// Stack model: tracks the evaluator stack and queues the result for each token
class rpn_stack_model;
  logic [VALUE_W-1:0] stack_mem [STACK_DEPTH_DEF];
  int unsigned        depth;
  eval_result_t       expected_q[$];
  int                 errors;

  function new();
    depth  = 0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted token and queue the result it must produce
  function void note_token(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
    eval_result_t r;
    longint       lhs;
    longint       rhs;
    longint       res;
    r.status = STATUS_OK;
    res      = 0;
    if (func == FUNC_PUSH) begin
      if (depth >= STACK_DEPTH_DEF) begin
        r.status = STATUS_OVER;
      end else begin
        stack_mem[depth] = value;
        depth++;
      end
    end else if (func > FUNC_DIV) begin
      r.status = STATUS_BADOP;
    end else if (depth < 2) begin
      r.status = STATUS_UNDER;
    end else begin
      rhs = longint'($signed(stack_mem[depth-1]));
      lhs = longint'($signed(stack_mem[depth-2]));
      case (func)
        FUNC_ADD: res = lhs + rhs;
        FUNC_SUB: res = lhs - rhs;
        FUNC_MUL: res = lhs * rhs;
        default: begin
          // 64-bit divide: min / -1 does not trap and wraps on truncation
          if (rhs == 0) r.status = STATUS_DIVZ;
          else res = lhs / rhs;
        end
      endcase
      if (r.status == STATUS_OK) begin
        depth--;
        stack_mem[depth-1] = res[VALUE_W-1:0];
      end
    end
    r.top   = (depth != 0) ? stack_mem[depth-1] : '0;
    r.depth = depth[DEPTH_W-1:0];
    expected_q.push_back(r);
  endfunction

  // Compare one result beat with the oldest expectation
  function void check_result(logic [OUT_W-1:0] data);
    eval_result_t       r;
    logic [VALUE_W-1:0]  got_top;
    logic [DEPTH_W-1:0]  got_depth;
    logic [STATUS_W-1:0] got_status;
    got_top    = data[VALUE_W-1:0];
    got_depth  = data[VALUE_W +: DEPTH_W];
    got_status = data[VALUE_W+DEPTH_W +: STATUS_W];
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none, got %h", $time, data);
      return;
    end
    r = expected_q.pop_front();
    if (got_top !== r.top) begin
      errors++;
      $display("%0t: top_value expected %h got %h", $time, r.top, got_top);
    end
    if (got_depth !== r.depth) begin
      errors++;
      $display("%0t: stack_depth expected %0d got %0d", $time, r.depth, got_depth);
    end
    if (got_status !== r.status) begin
      errors++;
      $display("%0t: status expected %0d got %0d", $time, r.status, got_status);
    end
  endfunction
endclass

module tb_top;

  localparam int RANDOM_TOKENS = 450;
  localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES = 64;    // above the multiply/divide latency
  localparam logic [FUNC_W-1:0] FUNC_MAX = '1;
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  rpn_stack_model rpn_model = new();
  int             tokens_sent = 0;
  bit             send_idle = 1'b0;
  bit             recv_idle = 1'b1;
  int             stall_left = 0;
  int             quiet_cycles = 0;

  postfix_stack_evaluator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Operand: small values, extremes, or fully random bits
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return VALUE_W'(int'($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '1;
          3: return '0;
          default: return VALUE_W'(1);
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_arith();
    return FUNC_W'($urandom_range(FUNC_ADD, FUNC_DIV));
  endfunction

  // Drive one token beat, hold it until accepted, and sometimes pause after it
  task automatic send_token(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-FUNC_W-VALUE_W){1'b0}}, value, func};
    do @(posedge clk); while (!s_tready);
    rpn_model.note_token(func, value);
    tokens_sent++;
    if (send_idle && $urandom_range(0, 9) < 3) begin
      gap = pick_gap();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drained();
    if (rpn_model.pending() != 0) begin
      s_tvalid <= 1'b0;
      while (rpn_model.pending() != 0) @(posedge clk);
    end
  endtask

  // Expression: pushes and operators, some unsupported, keeping the stack populated
  task automatic run_expression(input int n);
    for (int i = 0; i < n; i++) begin
      if (rpn_model.depth < 2 ||
          (rpn_model.depth < STACK_DEPTH_DEF - 2 && $urandom_range(0, 1) == 1))
        send_token(FUNC_PUSH, pick_value());
      else if ($urandom_range(0, 11) == 0)
        send_token(FUNC_W'($urandom_range(FUNC_DIV + 1, FUNC_MAX)), $urandom);
      else
        send_token(pick_arith(), $urandom);
    end
  endtask

  // Push to a full stack, then a few more to hit overflow
  task automatic run_fill();
    int extra;
    extra = $urandom_range(1, 3);
    while (rpn_model.depth < STACK_DEPTH_DEF) send_token(FUNC_PUSH, pick_value());
    repeat (extra) send_token(FUNC_PUSH, pick_value());
  endtask

  // Reduce the stack with operators, then run into underflow
  task automatic run_drain();
    int extra;
    extra = $urandom_range(1, 2);
    while (rpn_model.depth >= 2) send_token(pick_arith(), $urandom);
    repeat (extra) send_token(pick_arith(), $urandom);
  endtask

  task automatic run_noise(input int n);
    repeat (n) send_token(FUNC_W'($urandom_range(0, FUNC_MAX)), pick_value());
  endtask

  // Result side: random stalls, toggled in and out of stalling stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (recv_idle && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
    end
    if (!rst && $urandom_range(0, 199) == 0) recv_idle <= ~recv_idle;
  end

  // Result check on each accepted beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) rpn_model.check_result(m_tdata);
  end

  // Watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int first_random;
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: error cases on an empty stack, wraparound and divide corners
    send_token(FUNC_ADD, '0);
    send_token(FUNC_W'(FUNC_DIV + 1), '0);
    send_token(FUNC_W'(FUNC_DIV + 2), VAL_MIN);
    send_token(FUNC_MAX, '1);
    send_token(FUNC_PUSH, VAL_MAX);
    send_token(FUNC_SUB, '1);                 // one entry only: underflow
    send_token(FUNC_PUSH, VALUE_W'(1));
    send_token(FUNC_ADD, '0);                 // max + 1 wraps to min
    send_token(FUNC_PUSH, '1);
    send_token(FUNC_DIV, '0);                 // min / -1 wraps to min
    send_token(FUNC_PUSH, '0);
    send_token(FUNC_DIV, '1);                 // divide by zero, stack kept
    send_token(FUNC_MUL, '0);
    send_token(FUNC_PUSH, VALUE_W'(-7));
    send_token(FUNC_PUSH, VALUE_W'(2));
    send_token(FUNC_DIV, VAL_MAX);            // truncates toward zero
    send_token(FUNC_PUSH, VAL_MIN);
    send_token(FUNC_SUB, '0);
    send_token(FUNC_MAX, VAL_MIN);            // unsupported with a full operand pair
    send_token(FUNC_PUSH, VAL_MAX);
    send_token(FUNC_PUSH, VAL_MAX);
    send_token(FUNC_MUL, '0);
    send_token(FUNC_ADD, '1);
    send_token(FUNC_SUB, '0);
    wait_drained();

    // Random: sequences of mixed kind, the first one filling and emptying the stack
    first_random = tokens_sent;
    send_idle = 1'b1;
    run_fill();
    run_drain();
    while (tokens_sent - first_random < RANDOM_TOKENS) begin
      send_idle = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 60) run_expression($urandom_range(4, 16));
      else if (r < 70) run_drain();
      else if (r < 73) run_fill();
      else run_noise($urandom_range(2, 6));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rpn_model.errors == 0 && rpn_model.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pse_pkg.sv
src/pse_front.sv
src/pse_muldiv.sv
src/pse_back.sv
src/postfix_stack_evaluator.sv
src/pse_checker.sv
test/tb_top.sv
